/* rtl/bol_pkg.sv */
// Shared request codes, status codes and cell control word for the bounded ordered list.
// No dependencies; used by bol_cell and bounded_ordered_list_top.
`default_nettype none

package bol_pkg;

    // request codes
    localparam logic [1:0] REQ_APPEND      = 2'd0;
    localparam logic [1:0] REQ_REMOVE_VAL  = 2'd1;
    localparam logic [1:0] REQ_REMOVE_HEAD = 2'd2;
    localparam logic [1:0] REQ_READ        = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam int unsigned VAL_W = 32;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic cmp_en;       // capture the compare against the incoming value
        logic shift_match;  // close the gap behind the first match
        logic shift_all;    // drop the head: every cell takes its neighbor
        logic load_tail;    // append: the tail cell takes the stored value
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/bol_cell.sv */
// One storage cell of the list: holds one entry, compares it, and takes its right neighbor
// when the list closes a gap. Depends on bol_pkg.
`default_nettype none

module bol_cell (
    input  wire logic                                 i_clk,
    input  wire bol_pkg::t_cell_ctl                   i_ctl,
    input  wire logic signed [bol_pkg::VAL_W-1:0]     i_cmp_value,
    input  wire logic signed [bol_pkg::VAL_W-1:0]     i_wr_value,
    input  wire logic signed [bol_pkg::VAL_W-1:0]     i_next_val,
    input  wire logic                                 i_pos_valid,
    input  wire logic                                 i_is_tail,
    input  wire logic                                 i_found,
    output logic                                      o_found,
    output logic signed [bol_pkg::VAL_W-1:0]          o_val
);

    logic signed [bol_pkg::VAL_W-1:0] r_val;
    logic                             r_match;
    logic                             take_next;

    // found ripples toward the tail: set at and after the first live match
    assign o_found   = i_found | (r_match & i_pos_valid);
    assign take_next = (i_ctl.shift_match & o_found) | i_ctl.shift_all;
    assign o_val     = r_val;

    // compare captured in the accept cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_match <= (r_val == i_cmp_value);
        end
    end

    // entry storage; needs no reset, only live positions are ever read
    always_ff @(posedge i_clk) begin
        if (take_next) begin
            r_val <= i_next_val;
        end else if (i_ctl.load_tail && i_is_tail) begin
            r_val <= i_wr_value;
        end
    end

endmodule

`default_nettype wire

/* rtl/bounded_ordered_list_top.sv */
// Top level of the bounded ordered list: request/result handshakes, sequencer and cell row.
// Depends on bol_pkg and bol_cell.
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells, one entry per
// cell, kept compact from the head. A request word is handled in an accept and an execute cycle:
// in the accept cycle every cell compares its entry against the incoming value; in the execute
// cycle a found flag ripples down the row, cells behind the first match take their right
// neighbor, and the result word is loaded into the output register. A new word is taken only
// in the idle state, so not before the last result is loaded; o_stall is high in the execute
// state, which lasts until the output register is free. No clearing pass is needed after reset.
module bounded_ordered_list_top #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // request channel
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [1:0]                           i_req_type,
    input  wire logic signed [bol_pkg::VAL_W-1:0]     i_value,
    input  wire logic [3:0]                           i_index,
    // result channel
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [bol_pkg::VAL_W-1:0]          o_read_value,
    output logic [4:0]                                o_count,
    output logic [2:0]                                o_status
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = (CW > 4) ? CW : 4;
    localparam int unsigned XW = CW + 5;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [1:0]                       r_req;
    logic signed [bol_pkg::VAL_W-1:0] r_value;
    logic [3:0]                       r_idx;
    logic [CW-1:0]                    r_count, n_count;

    logic                             r_out_valid;
    logic signed [bol_pkg::VAL_W-1:0] r_rd;
    logic [4:0]                       r_cnt;
    logic [2:0]                       r_st;

    logic                             in_acc, out_free, exec_done;
    logic                             full, empty, out_range, found;
    logic signed [bol_pkg::VAL_W-1:0] rd_sel, n_rd;
    logic [2:0]                       n_st;
    logic [XW-1:0]                    cnt_wide;
    bol_pkg::t_cell_ctl               ctl;

    logic signed [bol_pkg::VAL_W-1:0] cell_val [DEPTH];
    logic [DEPTH:0]                   found_chain;

    // handshakes
    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign exec_done = (r_state == S_EXEC) && out_free;

    // list status flags
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign out_range = (IW'(r_idx) >= IW'(r_count));
    assign found     = found_chain[DEPTH];

    // cell controls
    always_comb begin
        ctl             = '0;
        ctl.cmp_en      = in_acc;
        ctl.shift_match = exec_done && (r_req == bol_pkg::REQ_REMOVE_VAL) && !empty;
        ctl.shift_all   = exec_done && (r_req == bol_pkg::REQ_REMOVE_HEAD) && !empty;
        ctl.load_tail   = exec_done && (r_req == bol_pkg::REQ_APPEND) && !full;
    end

    // cell row
    assign found_chain[0] = 1'b0;
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [bol_pkg::VAL_W-1:0] next_val;
        if (k == DEPTH - 1) begin : g_last
            assign next_val = cell_val[k];
        end else begin : g_mid
            assign next_val = cell_val[k+1];
        end
        bol_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_cmp_value (i_value),
            .i_wr_value  (r_value),
            .i_next_val  (next_val),
            .i_pos_valid (CW'(k) < r_count),
            .i_is_tail   (CW'(k) == r_count),
            .i_found     (found_chain[k]),
            .o_found     (found_chain[k+1]),
            .o_val       (cell_val[k])
        );
    end

    // read select by index
    always_comb begin
        rd_sel = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (IW'(k) == IW'(r_idx)) begin
                rd_sel = cell_val[k];
            end
        end
    end

    // result and count update
    always_comb begin
        n_rd    = '0;
        n_st    = bol_pkg::ST_OK;
        n_count = r_count;
        case (r_req)
            bol_pkg::REQ_APPEND: begin
                if (full) begin
                    n_st = bol_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            bol_pkg::REQ_REMOVE_VAL: begin
                if (empty) begin
                    n_st = bol_pkg::ST_EMPTY;
                end else if (!found) begin
                    n_st = bol_pkg::ST_NOT_FOUND;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            bol_pkg::REQ_REMOVE_HEAD: begin
                if (empty) begin
                    n_st = bol_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            bol_pkg::REQ_READ: begin
                if (out_range) begin
                    n_st = bol_pkg::ST_RANGE;
                end else begin
                    n_rd = rd_sel;
                end
            end
            default: begin
                n_st = bol_pkg::ST_OK;
            end
        endcase
    end

    assign cnt_wide = XW'(n_count);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_done) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request word capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req   <= i_req_type;
            r_value <= i_value;
            r_idx   <= i_index;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_rd  <= n_rd;
            r_cnt <= cnt_wide[4:0];
            r_st  <= n_st;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_rd;
    assign o_count      = r_cnt;
    assign o_status     = r_st;

endmodule

`default_nettype wire

/* sim/bounded_ordered_list_top_test.sv */
// Self-checking testbench for bounded_ordered_list_top: drives list requests, predicts
// every result word in a shadow list and compares them field by field.
// Depends on bol_pkg and the bounded_ordered_list_top RTL.
`timescale 1ns / 1ps

module bounded_ordered_list_top_test;

    localparam int unsigned LIST_DEPTH   = 16;
    localparam int unsigned RANDOM_WORDS = 1800;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DEAD_LIMIT   = 2000;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [31:0] read_value;
        logic [4:0]  count;
        logic [2:0]  status;
    } t_list_result;

    // Shadow copy of the list: predicts each result word and checks the DUT against it
    class list_shadow;
        logic [31:0]  entries [LIST_DEPTH];
        int unsigned  fill;
        t_list_result due_results [$];
        int unsigned  kind_seen [4];
        int unsigned  status_seen [5];
        int unsigned  checked;
        int unsigned  mismatches;
        int unsigned  unexpected;

        function new();
            fill       = 0;
            checked    = 0;
            mismatches = 0;
            unexpected = 0;
        endfunction

        // drop the entry at pos and pull the tail up by one
        function void close_gap(int unsigned pos);
            for (int unsigned j = pos; j + 1 < fill; j++)
                entries[j] = entries[j + 1];
            fill--;
        endfunction

        function void apply_request(logic [1:0] kind, logic [31:0] val, logic [3:0] idx);
            t_list_result res;
            int           pos;
            res.read_value = '0;
            res.status     = bol_pkg::ST_OK;
            pos            = -1;
            case (kind)
                bol_pkg::REQ_APPEND: begin
                    if (fill >= LIST_DEPTH) begin
                        res.status = bol_pkg::ST_FULL;
                    end else begin
                        entries[fill] = val;
                        fill++;
                    end
                end
                bol_pkg::REQ_REMOVE_VAL: begin
                    if (fill == 0) begin
                        res.status = bol_pkg::ST_EMPTY;
                    end else begin
                        // first match from the head wins
                        for (int i = 0; i < int'(fill); i++)
                            if (pos < 0 && entries[i] == val) pos = i;
                        if (pos < 0) res.status = bol_pkg::ST_NOT_FOUND;
                        else close_gap(pos);
                    end
                end
                bol_pkg::REQ_REMOVE_HEAD: begin
                    if (fill == 0) res.status = bol_pkg::ST_EMPTY;
                    else close_gap(0);
                end
                default: begin
                    if (idx >= fill) res.status = bol_pkg::ST_RANGE;
                    else res.read_value = entries[idx];
                end
            endcase
            res.count = 5'(fill);
            kind_seen[kind]++;
            status_seen[res.status]++;
            due_results.push_back(res);
        endfunction

        function void check_result(logic [31:0] rd, logic [4:0] cnt, logic [2:0] st);
            t_list_result want;
            if (due_results.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("unexpected result word: value %0d count %0d status %0d",
                             $signed(rd), cnt, st);
            end else begin
                want = due_results.pop_front();
                checked++;
                if (want.read_value !== rd || want.count !== cnt || want.status !== st) begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                        $display({"mismatch on result %0d: expected value %0d count %0d ",
                                  "status %0d, got value %0d count %0d status %0d"},
                                 checked, $signed(want.read_value), want.count, want.status,
                                 $signed(rd), cnt, st);
                end
            end
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function int unsigned failures();
            return mismatches + unexpected + due_results.size();
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [1:0]         i_req_type   = bol_pkg::REQ_APPEND;
    logic signed [31:0] i_value      = '0;
    logic [3:0]         i_index      = '0;
    logic               i_stall      = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic signed [31:0] o_read_value;
    logic [4:0]         o_count;
    logic [2:0]         o_status;

    list_shadow  shadow = new();
    logic        idle_off = 1'b0;
    logic [31:0] value_pool [8];
    int unsigned phase_mix [4] = '{85, 45, 15, 45};
    int unsigned hold_left  = 0;
    int unsigned sink_words = 0;
    int unsigned dead_cycles = 0;

    bounded_ordered_list_top #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .i_index      (i_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watch both channels: note accepted requests, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                shadow.check_result(o_read_value, o_count, o_status);
            if (i_valid && !o_stall)
                shadow.apply_request(i_req_type, i_value, i_index);
        end
    end

    // Result side: random stalls, plus two long hold-offs to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) sink_words <= sink_words + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else if (o_valid && !i_stall && (sink_words == 399 || sink_words == 1299)) begin
                hold_left <= HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= !idle_off && ($urandom_range(99) < 7);
            end
        end
    end

    // Timeout: nothing moving on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            dead_cycles <= 0;
        end else begin
            dead_cycles <= dead_cycles + 1;
            if (dead_cycles >= DEAD_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", DEAD_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Offer one request word and hold it until the block takes it
    task automatic send_word(input logic [1:0] kind, input logic [31:0] val,
                             input logic [3:0] idx);
        if (!idle_off) begin
            while ($urandom_range(99) < 7) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid    <= 1'b1;
        i_req_type <= kind;
        i_value    <= val;
        i_index    <= idx;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering until every predicted result has been returned
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0);
    endtask

    // Mostly values from a small pool so removes hit and duplicates appear
    function automatic logic [31:0] pick_value();
        if ($urandom_range(9) < 6) return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    initial begin
        int unsigned n;
        int unsigned append_pct;
        logic [1:0]  kind;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-list errors
        send_word(bol_pkg::REQ_READ,        32'h0, 4'd0);
        send_word(bol_pkg::REQ_REMOVE_HEAD, 32'h0, 4'd0);
        send_word(bol_pkg::REQ_REMOVE_VAL,  32'd5, 4'd0);
        // extreme values and a duplicate of the maximum
        send_word(bol_pkg::REQ_APPEND, 32'h8000_0000, 4'd0);
        send_word(bol_pkg::REQ_APPEND, 32'h7fff_ffff, 4'd0);
        send_word(bol_pkg::REQ_APPEND, 32'h0000_0000, 4'd0);
        send_word(bol_pkg::REQ_APPEND, 32'hffff_ffff, 4'd0);
        send_word(bol_pkg::REQ_APPEND, 32'h7fff_ffff, 4'd15);
        send_word(bol_pkg::REQ_READ,   32'h0, 4'd1);
        send_word(bol_pkg::REQ_READ,   32'h0, 4'd5);             // index equal to count
        send_word(bol_pkg::REQ_REMOVE_VAL, 32'd12345, 4'd0);      // not present
        send_word(bol_pkg::REQ_REMOVE_VAL, 32'h7fff_ffff, 4'd0);  // only the first copy goes
        send_word(bol_pkg::REQ_READ,   32'h0, 4'd3);
        send_word(bol_pkg::REQ_REMOVE_HEAD, 32'hffff_ffff, 4'd0);
        // fill to capacity, then one append too many
        for (int i = 0; i < 13; i++)
            send_word(bol_pkg::REQ_APPEND, $urandom, 4'($urandom_range(15)));
        send_word(bol_pkg::REQ_APPEND, 32'h1234_5678, 4'd0);
        send_word(bol_pkg::REQ_READ,   32'h0, 4'd15);

        // random: append bias swings so the list runs full and empty repeatedly
        for (n = 0; n < RANDOM_WORDS; n++) begin
            append_pct = phase_mix[(n / 120) % 4];
            if (n == 500) idle_off = 1'b1;
            if (n == 820) idle_off = 1'b0;
            if (n == 1000) wait_for_drain();
            if ($urandom_range(99) < append_pct) begin
                kind = bol_pkg::REQ_APPEND;
            end else begin
                case ($urandom_range(2))
                    0:       kind = bol_pkg::REQ_REMOVE_VAL;
                    1:       kind = bol_pkg::REQ_REMOVE_HEAD;
                    default: kind = bol_pkg::REQ_READ;
                endcase
            end
            if (kind == bol_pkg::REQ_APPEND || kind == bol_pkg::REQ_REMOVE_VAL)
                send_word(kind, pick_value(), 4'($urandom_range(15)));
            else
                send_word(kind, $urandom, 4'($urandom_range(15)));
        end

        wait_for_drain();
        repeat (8) @(posedge i_clk);

        $display({"Covered %0d appends, %0d value removes, %0d head removes, %0d reads; ",
                  "%0d results checked"},
                 shadow.kind_seen[bol_pkg::REQ_APPEND], shadow.kind_seen[bol_pkg::REQ_REMOVE_VAL],
                 shadow.kind_seen[bol_pkg::REQ_REMOVE_HEAD], shadow.kind_seen[bol_pkg::REQ_READ],
                 shadow.checked);
        $display("Status mix: ok %0d, full %0d, not found %0d, empty %0d, out of range %0d",
                 shadow.status_seen[bol_pkg::ST_OK], shadow.status_seen[bol_pkg::ST_FULL],
                 shadow.status_seen[bol_pkg::ST_NOT_FOUND], shadow.status_seen[bol_pkg::ST_EMPTY],
                 shadow.status_seen[bol_pkg::ST_RANGE]);
        if (shadow.failures() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d unexpected, %0d missing results",
                     shadow.mismatches, shadow.unexpected, shadow.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
